FILE: rtl/core/skvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String key/value table package
// Shared constants, command and status codes, and the key normalization
// function for the string key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

	// Default table geometry.
	localparam int TableEntriesDef = 16;
	localparam int KeyBytesDef     = 8;
	localparam int ValueBitsDef    = 32;

	// Field widths fixed by the port list.
	localparam int KeyTextBits  = 64;
	localparam int ValueOutBits = 32;
	localparam int UsedBits     = 5;

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] status_t;

	// Command codes. The unused code behaves as a lookup.
	localparam cmd_t CMD_LOOKUP = 2'd0;
	localparam cmd_t CMD_INSERT = 2'd1;
	localparam cmd_t CMD_DELETE = 2'd2;

	// Result status codes.
	localparam status_t ST_DONE      = 2'd0;
	localparam status_t ST_DUPLICATE = 2'd1;
	localparam status_t ST_FULL      = 2'd2;
	localparam status_t ST_NOT_FOUND = 2'd3;

	localparam logic [7:0] NUL_BYTE = 8'h00;

	// Keep the bytes before the first null byte, within the first nbytes bytes.
	function automatic logic [KeyTextBits-1:0] normalize_key(
		input logic [KeyTextBits-1:0] raw,
		input int                     nbytes
	);
		logic [KeyTextBits-1:0] norm;
		logic                   ended;
		norm  = '0;
		ended = 1'b0;
		for (int b = 0; b < KeyTextBits / 8; b++) begin
			if (b >= nbytes || raw[8*b +: 8] == NUL_BYTE) begin
				ended = 1'b1;
			end
			if (!ended) begin
				norm[8*b +: 8] = raw[8*b +: 8];
			end
		end
		return norm;
	endfunction

endpackage

FILE: rtl/core/skvt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module skvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Storage array; contents are undefined until written.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/string_key_value_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String key/value table
// Packed, insertion-ordered table of string keys and values with lookup,
// insert and delete by linear search over a key RAM and a value RAM.
// ----------------------------------------------------------------------------
//
// Channel   Handshake            Payload
// command   start in, busy out   command, key_text, value_in
// result    done out (strobe)    key_found, value_out, status, entries_used
//
// A command is taken at a rising edge with start high and busy low.
// The search reads one stored entry per cycle from the key and value RAMs.
// A delete that hits moves every later pair down one slot to close the gap,
// so the table stays packed in insertion order.
// The result is shown for one cycle with done high; the receiver cannot
// stall it. Reset empties the table at once; no clearing pass is needed.
//
module string_key_value_table #(
	parameter int TABLE_ENTRIES = skvt_pkg::TableEntriesDef,
	parameter int KEY_BYTES     = skvt_pkg::KeyBytesDef,
	parameter int VALUE_BITS    = skvt_pkg::ValueBitsDef
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        command,
	input  logic [skvt_pkg::KeyTextBits-1:0]  key_text,
	input  logic [31:0]                       value_in,
	output logic                              done,
	output logic                              key_found,
	output logic [skvt_pkg::ValueOutBits-1:0] value_out,
	output logic [1:0]                        status,
	output logic [skvt_pkg::UsedBits-1:0]     entries_used
);
	import skvt_pkg::*;

	localparam int KW = KEY_BYTES * 8;
	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int PW = CW + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_MISS
	} fsm_t;

	fsm_t                  state_q;
	cmd_t                  cmd_q;
	logic [KW-1:0]         key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [AW-1:0]         ptr_q;
	logic [CW-1:0]         count_q;

	logic                    done_q;
	logic                    found_q;
	logic [ValueOutBits-1:0] vout_q;
	status_t                 status_q;

	// RAM ports.
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [KW-1:0]         key_wd;
	logic [VALUE_BITS-1:0] val_wd;
	logic [AW-1:0]         rd_addr;
	logic [KW-1:0]         rd_key;
	logic [VALUE_BITS-1:0] rd_val;

	logic [PW-1:0] nxt1;
	logic [PW-1:0] nxt2;
	logic [PW-1:0] count_w;
	logic          key_match;
	logic          table_full;
	logic [KW-1:0] key_norm;

	// Slot arithmetic is one bit wider than the count so it cannot wrap.
	assign nxt1       = PW'(ptr_q) + PW'(1);
	assign nxt2       = PW'(ptr_q) + PW'(2);
	assign count_w    = PW'(count_q);
	assign key_match  = (rd_key == key_q);
	assign table_full = (count_q == CW'(TABLE_ENTRIES));
	assign key_norm   = KW'(normalize_key(key_text, KEY_BYTES));

	// Read address: entry 0 on acceptance, the next entry while searching,
	// and the entry two ahead of the write slot while closing a gap.
	always_comb begin
		unique case (state_q)
			S_SEARCH: rd_addr = AW'(nxt1);
			S_SHIFT:  rd_addr = AW'(nxt2);
			default:  rd_addr = '0;
		endcase
	end

	// Write port: move entries down on delete, append on a successful insert.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		key_wd  = key_q;
		val_wd  = val_q;
		unique case (state_q)
			S_SHIFT: begin
				wr_en  = 1'b1;
				key_wd = rd_key;
				val_wd = rd_val;
			end
			S_MISS: begin
				wr_en   = (cmd_q == CMD_INSERT) && !table_full;
				wr_addr = count_q[AW-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	skvt_ram #(
		.WIDTH(KW),
		.DEPTH(TABLE_ENTRIES)
	) u_key_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(key_wd),
		.rd_addr(rd_addr),
		.rd_data(rd_key)
	);

	skvt_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(TABLE_ENTRIES)
	) u_value_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(val_wd),
		.rd_addr(rd_addr),
		.rd_data(rd_val)
	);

	// Sequencer: state, pointer, pair count and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cmd_q    <= CMD_LOOKUP;
			key_q    <= '0;
			val_q    <= '0;
			ptr_q    <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			vout_q   <= '0;
			status_q <= ST_DONE;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= command;
						key_q   <= key_norm;
						val_q   <= VALUE_BITS'(value_in);
						ptr_q   <= '0;
						state_q <= (count_q == '0) ? S_MISS : S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (key_match) begin
						found_q  <= 1'b1;
						vout_q   <= '0;
						status_q <= ST_DONE;
						unique case (cmd_q)
							CMD_DELETE: begin
								if (nxt1 < count_w) begin
									state_q <= S_SHIFT;
								end else begin
									count_q <= count_q - CW'(1);
									done_q  <= 1'b1;
									state_q <= S_IDLE;
								end
							end
							CMD_INSERT: begin
								status_q <= ST_DUPLICATE;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end
							default: begin
								vout_q  <= ValueOutBits'(rd_val);
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						endcase
					end else if (nxt1 == count_w) begin
						state_q <= S_MISS;
					end else begin
						ptr_q <= AW'(nxt1);
					end
				end
				S_SHIFT: begin
					if (nxt2 < count_w) begin
						ptr_q <= AW'(nxt1);
					end else begin
						count_q <= count_q - CW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MISS: begin
					found_q <= 1'b0;
					vout_q  <= '0;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (cmd_q == CMD_INSERT) begin
						if (table_full) begin
							status_q <= ST_FULL;
						end else begin
							status_q <= ST_DONE;
							count_q  <= count_q + CW'(1);
						end
					end else begin
						status_q <= ST_NOT_FOUND;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign key_found    = found_q;
	assign value_out    = vout_q;
	assign status       = status_q;
	assign entries_used = UsedBits'(count_q);

	// The pair count never exceeds the table size.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_ENTRIES))
		else $error("pair count above table size");

	// A write only lands inside the packed region or at its end.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (CW'(wr_addr) <= count_q))
		else $error("RAM write outside packed region");

	// A successful insert grows the table by exactly one pair.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && cmd_q == CMD_INSERT && status_q == ST_DONE)
			|-> (count_q == CW'($past(count_q) + CW'(1))))
		else $error("insert did not add one pair");

	// A hit reports either completion or a duplicate insert.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && found_q) |-> (status_q == ST_DONE || status_q == ST_DUPLICATE))
		else $error("hit with miss status");

	// A result only follows work on a command.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q != S_IDLE))
		else $error("result without a command in progress");

endmodule

FILE: verif/string_key_value_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String key/value table testbench
// Drives lookup, insert and delete commands and the unused code into the
// table with random gaps, predicts every result from a model of the packed
// table kept here, and compares each strobed result field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module string_key_value_table_tb;
	import skvt_pkg::*;

	localparam int   HalfPeriod  = 4;
	localparam int   PoolKeys    = 20;
	localparam int   RandomItems = 800;
	localparam int   PhaseItems  = 60;
	localparam int   MaxGap      = 14;
	localparam int   DrainCycles = 40;
	localparam cmd_t CMD_UNUSED  = 2'd3;

	// One predicted result.
	typedef struct {
		logic                    found;
		logic [ValueOutBits-1:0] value;
		status_t                 status;
		logic [UsedBits-1:0]     used;
	} table_result_t;

	// Table model and queue of predicted results.
	class table_scoreboard;
		logic [KeyTextBits-1:0] keys[TableEntriesDef];
		logic [31:0]            vals[TableEntriesDef];
		int                     pairs;
		table_result_t          result_q[$];
		int                     errors;

		function new();
			pairs  = 0;
			errors = 0;
		endfunction

		// Cut the key at its first null byte.
		function logic [KeyTextBits-1:0] key_of(logic [KeyTextBits-1:0] raw);
			int                     len;
			logic [KeyTextBits-1:0] mask;
			len = KeyBytesDef;
			for (int b = KeyBytesDef - 1; b >= 0; b--) begin
				if (raw[8*b +: 8] == 8'h00) begin
					len = b;
				end
			end
			mask = (len == 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
			return raw & mask;
		endfunction

		// Update the table for an accepted transfer and queue its result.
		function void note_command(cmd_t cmd, logic [KeyTextBits-1:0] raw,
				logic [31:0] value_in);
			logic [KeyTextBits-1:0] key;
			int                     slot;
			table_result_t          res;
			key  = key_of(raw);
			slot = pairs;
			for (int i = pairs - 1; i >= 0; i--) begin
				if (keys[i] == key) begin
					slot = i;
				end
			end
			res.found  = (slot < pairs);
			res.value  = '0;
			res.status = ST_DONE;
			if (cmd == CMD_INSERT) begin
				if (res.found) begin
					res.status = ST_DUPLICATE;
				end else if (pairs >= TableEntriesDef) begin
					res.status = ST_FULL;
				end else begin
					keys[pairs] = key;
					vals[pairs] = value_in;
					pairs++;
				end
			end else if (cmd == CMD_DELETE) begin
				if (!res.found) begin
					res.status = ST_NOT_FOUND;
				end else begin
					for (int i = slot; i < pairs - 1; i++) begin
						keys[i] = keys[i+1];
						vals[i] = vals[i+1];
					end
					pairs--;
				end
			end else begin
				// Lookup, and the unused code that behaves as one.
				if (res.found) begin
					res.value = vals[slot];
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			res.used = UsedBits'(pairs);
			result_q.push_back(res);
		endfunction

		// Compare a strobed result with the oldest prediction.
		function void check_result(logic found, logic [ValueOutBits-1:0] value,
				status_t status, logic [UsedBits-1:0] used);
			table_result_t exp_res;
			if (result_q.size() == 0) begin
				$error("result strobed with no command outstanding");
				errors++;
				return;
			end
			exp_res = result_q.pop_front();
			if (found !== exp_res.found) begin
				$error("key_found: expected %0d, got %0d", exp_res.found, found);
				errors++;
			end
			if (value !== exp_res.value) begin
				$error("value_out: expected %h, got %h", exp_res.value, value);
				errors++;
			end
			if (status !== exp_res.status) begin
				$error("status: expected %0d, got %0d", exp_res.status, status);
				errors++;
			end
			if (used !== exp_res.used) begin
				$error("entries_used: expected %0d, got %0d", exp_res.used, used);
				errors++;
			end
		endfunction

		function int pending();
			return result_q.size();
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [1:0]              command = CMD_LOOKUP;
	logic [KeyTextBits-1:0]  key_text = '0;
	logic [31:0]             value_in = '0;
	logic                    done;
	logic                    key_found;
	logic [ValueOutBits-1:0] value_out;
	logic [1:0]              status;
	logic [UsedBits-1:0]     entries_used;

	table_scoreboard         sb = new();
	logic [KeyTextBits-1:0]  key_pool[PoolKeys];
	int                      key_len[PoolKeys];
	bit                      no_idle = 1'b0;

	string_key_value_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.key_text     (key_text),
		.value_in     (value_in),
		.done         (done),
		.key_found    (key_found),
		.value_out    (value_out),
		.status       (status),
		.entries_used (entries_used)
	);

	always #(HalfPeriod) clk = ~clk;

	// Every strobed result is checked at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(key_found, value_out, status, entries_used);
		end
	end

	// Issue one command after a random gap and wait for its transfer.
	task automatic send_command(cmd_t cmd, logic [KeyTextBits-1:0] key,
			logic [31:0] value);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MaxGap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		command  <= cmd;
		key_text <= key;
		value_in <= value;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_command(cmd, key, value);
	endtask

	// Pick a pool key, sometimes with junk bytes after its null.
	function automatic logic [KeyTextBits-1:0] pool_key();
		int                     idx;
		logic [KeyTextBits-1:0] key;
		idx = $urandom_range(0, PoolKeys - 1);
		key = key_pool[idx];
		if (key_len[idx] < KeyBytesDef - 1 && $urandom_range(0, 3) == 0) begin
			for (int b = key_len[idx] + 1; b < KeyBytesDef; b++) begin
				key[8*b +: 8] = 8'($urandom);
			end
		end
		return key;
	endfunction

	// Command mix leans toward filling or emptying, by phase.
	function automatic cmd_t pick_command(bit filling);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			return CMD_UNUSED;
		end else if (roll < 25) begin
			return CMD_LOOKUP;
		end else if (roll < (filling ? 85 : 45)) begin
			return CMD_INSERT;
		end
		return CMD_DELETE;
	endfunction

	initial begin
		logic [KeyTextBits-1:0] key;
		logic [KeyTextBits-1:0] last_fill;
		bit                     filling;

		// Pool of keys of every length, with nonzero bytes.
		for (int i = 0; i < PoolKeys; i++) begin
			key_len[i]  = (i < 9) ? i : $urandom_range(0, KeyBytesDef);
			key_pool[i] = '0;
			for (int b = 0; b < key_len[i]; b++) begin
				key_pool[i][8*b +: 8] = 8'($urandom_range(1, 255));
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: misses on an empty table, the empty key, junk after
		// the null, a key with no null, the unused code, then a full table.
		no_idle = ($urandom_range(0, 1) == 0);
		send_command(CMD_LOOKUP, 64'h0000_0000_0063_6261, 32'h0);
		send_command(CMD_DELETE, 64'h0000_0000_0063_6261, 32'h0);
		send_command(CMD_INSERT, 64'h0, 32'hFFFF_FFFF);
		send_command(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 32'h0);
		send_command(CMD_INSERT, 64'h0000_0000_0063_6261, 32'h0);
		send_command(CMD_INSERT, 64'hA55A_C300_0063_6261, 32'h1111_1111);
		send_command(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678);
		send_command(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		last_fill = '0;
		for (int i = 0; i < TableEntriesDef - 3; i++) begin
			last_fill = 64'h0000_0000_0000_616B + (64'(i) << 8);
			send_command(CMD_INSERT, last_fill, $urandom);
		end
		send_command(CMD_INSERT, 64'h0000_0000_0000_7A7A, 32'hDEAD_BEEF);
		send_command(CMD_DELETE, 64'h0, 32'h0);
		send_command(CMD_DELETE, last_fill, 32'h0);
		send_command(CMD_LOOKUP, 64'h0000_0000_0063_6261, 32'h0);

		// Random: pool keys in filling and emptying phases, some noise.
		filling = 1'b1;
		for (int n = 0; n < RandomItems; n++) begin
			if (n % PhaseItems == 0) begin
				filling = ~filling;
				no_idle = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 7) == 0) begin
				key = {$urandom, $urandom};
			end else begin
				key = pool_key();
			end
			send_command(pick_command(filling), key, $urandom);
		end
		start <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

endmodule
